// ===== rtl/core/gmg_pkg.sv =====
// Shared constants, widths, register codes and exp tables for the Gaussian
// model and gradient unit. No dependencies.
package gmg_pkg;

  localparam int COORD_BITS  = 12;
  localparam int FRAC_BITS   = 16;
  localparam int PARAM_COUNT = 6;

  localparam int DATA_W    = 32;
  localparam int SIG_W     = 31;
  localparam int MASK_W    = 6;
  localparam int CFG_IDX_W = 3;

  // Offset from centre, magnitude ratios and products
  localparam int DX_W   = ((COORD_BITS + FRAC_BITS > DATA_W - 1) ?
                           COORD_BITS + FRAC_BITS : DATA_W - 1) + 2;
  localparam int RAT_W  = FRAC_BITS + 4;
  localparam int RAT2_W = FRAC_BITS + 7;
  localparam int E_W    = FRAC_BITS + 1;
  localparam int M_W    = DATA_W + 6;
  localparam int NUM_W  = ((DX_W > M_W) ? DX_W : M_W) + FRAC_BITS;

  // Divider: quotient bits and pipeline depth
  localparam int QUO_W   = DATA_W + 1;
  localparam int DIV_LAT = QUO_W + 1;

  // exp(-a): Q30 tables
  localparam int P_W         = 31;
  localparam int EXP_INT_MAX = 20;
  localparam int EI_W        = 5;
  localparam int EXP_INT_N   = 1 << EI_W;

  localparam int PIPE_LAT = 2 + DIV_LAT + 3 + 1 + FRAC_BITS + 1 + 3 + DIV_LAT + 1;

  localparam logic [RAT_W-1:0]  RAT_EIGHT = RAT_W'(8) << FRAC_BITS;
  localparam logic [SIG_W-1:0]  SIG_RESET = SIG_W'(1) << FRAC_BITS;
  localparam logic [DATA_W-1:0] AMP_RESET = DATA_W'(64'd200 << FRAC_BITS);
  localparam logic [DATA_W-1:0] ONE_FIX   = DATA_W'(1) << FRAC_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_OFFSET = 3'd0,
    REG_AMPLITUDE   = 3'd1,
    REG_CENTER_X    = 3'd2,
    REG_CENTER_Y    = 3'd3,
    REG_WIDTH_X     = 3'd4,
    REG_WIDTH_Y     = 3'd5,
    REG_FIT_MASK    = 3'd6
  } cfg_reg_e;

  typedef logic [P_W-1:0] q30_t;
  typedef q30_t exp_int_tab_t [EXP_INT_N];
  typedef q30_t exp_frac_tab_t [FRAC_BITS+1];

  // exp(-2^-sh) in Q30 from a truncated alternating series in Q62
  function automatic q30_t exp_series(input int unsigned sh);
    logic [63:0] s;
    logic [63:0] term;
    s    = 64'd1 << 62;
    term = 64'd1 << 62;
    for (int unsigned k = 1; k <= 30; k++) begin
      term = (term >> sh) / 64'(k);
      if (k[0]) s = s - term;
      else      s = s + term;
    end
    return P_W'((s + (64'd1 << 31)) >> 32);
  endfunction

  function automatic exp_int_tab_t build_int_tab();
    exp_int_tab_t tab;
    logic [63:0]  acc;
    for (int i = 0; i < EXP_INT_N; i++) tab[i] = '0;
    tab[0] = P_W'(1) << 30;
    tab[1] = exp_series(0);
    for (int i = 2; i <= EXP_INT_MAX; i++) begin
      acc    = (64'(tab[i-1]) * 64'(tab[1]) + (64'd1 << 29)) >> 30;
      tab[i] = acc[P_W-1:0];
    end
    return tab;
  endfunction

  function automatic exp_frac_tab_t build_frac_tab();
    exp_frac_tab_t tab;
    tab[0] = P_W'(1) << 30;
    for (int i = 1; i <= FRAC_BITS; i++) tab[i] = exp_series(i);
    return tab;
  endfunction

  localparam exp_int_tab_t  EXP_INT_TAB  = build_int_tab();
  localparam exp_frac_tab_t EXP_FRAC_TAB = build_frac_tab();

endpackage

// ===== rtl/core/gmg_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// Depends on gmg_pkg for widths.
module gmg_div (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [gmg_pkg::NUM_W-1:0]   num_i,
  input  logic [gmg_pkg::SIG_W-1:0]   den_i,
  output logic [gmg_pkg::QUO_W-1:0]   quo_o,
  output logic                        ovf_o
);

  localparam int QW = gmg_pkg::QUO_W;
  localparam int SW = gmg_pkg::SIG_W;
  localparam int NW = gmg_pkg::NUM_W;

  logic [SW-1:0] rem_q [QW+1];
  logic [QW-1:0] low_q [QW+1];
  logic [QW-1:0] quo_q [QW+1];
  logic          ovf_q [QW+1];

  logic [NW-1:0] upper;
  logic          ovf_d;

  assign upper = num_i >> QW;
  assign ovf_d = upper >= NW'(den_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= ovf_d ? '0 : upper[SW-1:0];
      low_q[0] <= num_i[QW-1:0];
      quo_q[0] <= '0;
      ovf_q[0] <= ovf_d;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_stage
    logic [SW:0] trial;
    logic [SW:0] diff;
    logic        ge;
    assign trial = {rem_q[k-1], low_q[k-1][QW-1]};
    assign diff  = trial - {1'b0, den_i};
    assign ge    = trial >= {1'b0, den_i};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? diff[SW-1:0] : trial[SW-1:0];
        low_q[k] <= low_q[k-1] << 1;
        quo_q[k] <= {quo_q[k-1][QW-2:0], ge};
        ovf_q[k] <= ovf_q[k-1];
      end
    end
  end

  assign quo_o = quo_q[QW];
  assign ovf_o = ovf_q[QW];

endmodule

// ===== rtl/core/gaussian_2d_model_gradient_unit.sv =====
// Gaussian model value and Jacobian per pixel, Q16.16, deep pipeline.
// Throughput one pixel per cycle while out_ready_i takes each result.
// The two divider chains and the 16-step exp chain make up most of the pipeline.
// A result not taken stalls the whole pipeline in place; nothing is dropped.
// Reset clears all valid bits and loads register defaults; no clearing pass.
// Depends on gmg_pkg and gmg_div.
module gaussian_2d_model_gradient_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [gmg_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [gmg_pkg::DATA_W-1:0]          cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [gmg_pkg::COORD_BITS-1:0]      pixel_x_i,
  input  logic [gmg_pkg::COORD_BITS-1:0]      pixel_y_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [gmg_pkg::DATA_W-1:0]   model_value_o,
  output logic signed [gmg_pkg::DATA_W-1:0]   deriv_offset_o,
  output logic signed [gmg_pkg::DATA_W-1:0]   deriv_amplitude_o,
  output logic signed [gmg_pkg::DATA_W-1:0]   deriv_center_x_o,
  output logic signed [gmg_pkg::DATA_W-1:0]   deriv_center_y_o,
  output logic signed [gmg_pkg::DATA_W-1:0]   deriv_width_x_o,
  output logic signed [gmg_pkg::DATA_W-1:0]   deriv_width_y_o,
  output logic                                range_error_o
);

  localparam int F   = gmg_pkg::FRAC_BITS;
  localparam int DW  = gmg_pkg::DATA_W;
  localparam int QW  = gmg_pkg::QUO_W;
  localparam int NW  = gmg_pkg::NUM_W;
  localparam int R2W = gmg_pkg::RAT2_W;
  localparam int RW  = gmg_pkg::RAT_W;
  localparam int PW  = gmg_pkg::P_W;
  localparam int EW  = gmg_pkg::E_W;
  localparam int MW  = gmg_pkg::M_W;
  localparam int DL  = gmg_pkg::DIV_LAT;
  localparam int PL  = gmg_pkg::PIPE_LAT;
  localparam int NLN = gmg_pkg::PARAM_COUNT - 2;

  localparam logic [QW:0] SAT_POS = (QW+1)'(33'h07FFFFFFF);
  localparam logic [QW:0] SAT_NEG = (QW+1)'(33'h080000000);

  typedef struct packed {
    logic negx;
    logic negy;
    logic farx;
    logic fary;
  } ax_side_t;

  typedef struct packed {
    logic [RW-1:0]  rx;
    logic [RW-1:0]  ry;
    logic [R2W-1:0] rx2;
    logic [R2W-1:0] ry2;
    logic           negx;
    logic           negy;
  } rat_t;

  typedef struct packed {
    logic [EW-1:0] e;
    logic [DW-1:0] aem;
    logic          negx;
    logic          negy;
  } dv_side_t;

  // Configuration registers
  logic signed [DW-1:0]            base_offset_q, amplitude_q, center_x_q, center_y_q;
  logic [gmg_pkg::SIG_W-1:0]       width_x_q, width_y_q;
  logic [gmg_pkg::MASK_W-1:0]      fit_mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_offset_q <= '0;
      amplitude_q   <= gmg_pkg::AMP_RESET;
      center_x_q    <= '0;
      center_y_q    <= '0;
      width_x_q     <= gmg_pkg::SIG_RESET;
      width_y_q     <= gmg_pkg::SIG_RESET;
      fit_mask_q    <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gmg_pkg::REG_BASE_OFFSET: base_offset_q <= cfg_wdata_i;
        gmg_pkg::REG_AMPLITUDE:   amplitude_q   <= cfg_wdata_i;
        gmg_pkg::REG_CENTER_X:    center_x_q    <= cfg_wdata_i;
        gmg_pkg::REG_CENTER_Y:    center_y_q    <= cfg_wdata_i;
        gmg_pkg::REG_WIDTH_X:     width_x_q     <= cfg_wdata_i[gmg_pkg::SIG_W-1:0];
        gmg_pkg::REG_WIDTH_Y:     width_y_q     <= cfg_wdata_i[gmg_pkg::SIG_W-1:0];
        gmg_pkg::REG_FIT_MASK:    fit_mask_q    <= cfg_wdata_i[gmg_pkg::MASK_W-1:0];
        default: ;
      endcase
    end
  end

  logic          sig_zero;
  logic          nega;
  logic [DW-1:0] amag;
  assign sig_zero = (width_x_q == '0) || (width_y_q == '0);
  assign nega     = amplitude_q[DW-1];
  assign amag     = nega ? (DW'(0) - amplitude_q) : amplitude_q;

  // Pipeline advance: hold everything while the result waits
  logic          en;
  logic [PL-1:0] v_q;
  assign en          = !v_q[PL-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = v_q[PL-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else if (en) v_q <= {v_q[PL-2:0], in_valid_i};
  end

  // Stage 1: offsets from centre
  logic signed [gmg_pkg::DX_W-1:0] dx_q, dy_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q <= gmg_pkg::DX_W'({pixel_x_i, {F{1'b0}}}) - gmg_pkg::DX_W'(center_x_q);
      dy_q <= gmg_pkg::DX_W'({pixel_y_i, {F{1'b0}}}) - gmg_pkg::DX_W'(center_y_q);
    end
  end

  // Stage 2: magnitudes, far test, ratio numerators
  logic [gmg_pkg::DX_W-1:0] adx, ady;
  logic [NW-1:0]            numx_q, numy_q;
  ax_side_t                 ax_q;
  assign adx = dx_q[gmg_pkg::DX_W-1] ? -dx_q : dx_q;
  assign ady = dy_q[gmg_pkg::DX_W-1] ? -dy_q : dy_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax_q.negx <= dx_q[gmg_pkg::DX_W-1];
      ax_q.negy <= dy_q[gmg_pkg::DX_W-1];
      ax_q.farx <= NW'(adx) >= (NW'(width_x_q) << 3);
      ax_q.fary <= NW'(ady) >= (NW'(width_y_q) << 3);
      numx_q    <= (NW'(adx) << F) + NW'(width_x_q >> 1);
      numy_q    <= (NW'(ady) << F) + NW'(width_y_q >> 1);
    end
  end

  logic [QW-1:0] qx, qy;
  logic          ox, oy;
  gmg_div u_div_rx (.clk_i, .en_i(en), .num_i(numx_q), .den_i(width_x_q),
                    .quo_o(qx), .ovf_o(ox));
  gmg_div u_div_ry (.clk_i, .en_i(en), .num_i(numy_q), .den_i(width_y_q),
                    .quo_o(qy), .ovf_o(oy));

  ax_side_t ax_dly_q [DL];
  always_ff @(posedge clk_i) begin
    if (en) begin
      ax_dly_q[0] <= ax_q;
      for (int i = 1; i < DL; i++) ax_dly_q[i] <= ax_dly_q[i-1];
    end
  end

  // Stage 3: ratios, clamp at eight sigma
  rat_t s3_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_q.rx   <= ax_dly_q[DL-1].farx ? gmg_pkg::RAT_EIGHT : qx[RW-1:0];
      s3_q.ry   <= ax_dly_q[DL-1].fary ? gmg_pkg::RAT_EIGHT : qy[RW-1:0];
      s3_q.rx2  <= '0;
      s3_q.ry2  <= '0;
      s3_q.negx <= ax_dly_q[DL-1].negx;
      s3_q.negy <= ax_dly_q[DL-1].negy;
    end
  end

  // Stage 4: squares
  logic [2*RW-1:0] sqx, sqy;
  rat_t            s4_q;
  assign sqx = (2*RW)'(s3_q.rx) * (2*RW)'(s3_q.rx) + (2*RW)'(1 << (F - 1));
  assign sqy = (2*RW)'(s3_q.ry) * (2*RW)'(s3_q.ry) + (2*RW)'(1 << (F - 1));
  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_q.rx   <= s3_q.rx;
      s4_q.ry   <= s3_q.ry;
      s4_q.rx2  <= sqx[F +: R2W];
      s4_q.ry2  <= sqy[F +: R2W];
      s4_q.negx <= s3_q.negx;
      s4_q.negy <= s3_q.negy;
    end
  end

  // Stage 5: exponent argument
  logic [R2W:0]   asum;
  logic [R2W-1:0] a_q;
  rat_t           s5_q;
  assign asum = {1'b0, s4_q.rx2} + {1'b0, s4_q.ry2};
  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q  <= asum[R2W:1];
      s5_q <= s4_q;
    end
  end

  // exp chain: integer table, then one fractional bit per stage
  logic [PW-1:0] p_q   [F+1];
  logic [F-1:0]  fr_q  [F+1];
  rat_t          rt_q  [F+1];
  logic [R2W-F-1:0] a_int;
  assign a_int = a_q[R2W-1:F];

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q[0]  <= (sig_zero || a_int > (R2W-F)'(gmg_pkg::EXP_INT_MAX)) ? '0 :
                 gmg_pkg::EXP_INT_TAB[a_int[gmg_pkg::EI_W-1:0]];
      fr_q[0] <= a_q[F-1:0];
      rt_q[0] <= s5_q;
    end
  end

  for (genvar j = 1; j <= F; j++) begin : g_exp
    logic [2*PW-1:0] prod;
    assign prod = (2*PW)'(p_q[j-1]) * (2*PW)'(gmg_pkg::EXP_FRAC_TAB[j])
                + (2*PW)'(1 << 29);
    always_ff @(posedge clk_i) begin
      if (en) begin
        p_q[j]  <= fr_q[j-1][F-j] ? prod[30 +: PW] : p_q[j-1];
        fr_q[j] <= fr_q[j-1];
        rt_q[j] <= rt_q[j-1];
      end
    end
  end

  // Round to fixed point
  logic [PW:0]   psum;
  logic [EW-1:0] e_q;
  rat_t          re_q;
  assign psum = {1'b0, p_q[F]} + (PW+1)'(1 << (29 - F));
  always_ff @(posedge clk_i) begin
    if (en) begin
      e_q  <= psum[30-F +: EW];
      re_q <= rt_q[F];
    end
  end

  // |A| * e
  logic [DW+EW-1:0] aprod;
  logic [DW-1:0]    aem_q;
  logic [EW-1:0]    ea_q;
  rat_t             ra_q;
  assign aprod = (DW+EW)'(amag) * (DW+EW)'(e_q) + (DW+EW)'(1 << (F - 1));
  always_ff @(posedge clk_i) begin
    if (en) begin
      aem_q <= aprod[F +: DW];
      ea_q  <= e_q;
      ra_q  <= re_q;
    end
  end

  // Lanes: centre x, centre y, sigma x, sigma y
  logic [R2W-1:0] lane_r [NLN];
  assign lane_r[0] = R2W'(ra_q.rx);
  assign lane_r[1] = R2W'(ra_q.ry);
  assign lane_r[2] = ra_q.rx2;
  assign lane_r[3] = ra_q.ry2;

  logic [gmg_pkg::SIG_W-1:0] lane_s [NLN];
  assign lane_s[0] = width_x_q;
  assign lane_s[1] = width_y_q;
  assign lane_s[2] = width_x_q;
  assign lane_s[3] = width_y_q;

  logic [MW-1:0] m_q  [NLN];
  logic [NW-1:0] nd_q [NLN];
  dv_side_t      sm_q, sn_q;

  for (genvar k = 0; k < NLN; k++) begin : g_lane
    logic [DW+R2W-1:0] mprod;
    assign mprod = (DW+R2W)'(aem_q) * (DW+R2W)'(lane_r[k]) + (DW+R2W)'(1 << (F - 1));
    always_ff @(posedge clk_i) begin
      if (en) begin
        m_q[k]  <= mprod[F +: MW];
        nd_q[k] <= (NW'(m_q[k]) << F) + NW'(lane_s[k] >> 1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sm_q.e    <= ea_q;
      sm_q.aem  <= aem_q;
      sm_q.negx <= ra_q.negx;
      sm_q.negy <= ra_q.negy;
      sn_q      <= sm_q;
    end
  end

  logic [QW-1:0] dq [NLN];
  logic          dovf [NLN];
  for (genvar k = 0; k < NLN; k++) begin : g_div
    gmg_div u_div (.clk_i, .en_i(en), .num_i(nd_q[k]), .den_i(lane_s[k]),
                   .quo_o(dq[k]), .ovf_o(dovf[k]));
  end

  dv_side_t dv_dly_q [DL];
  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_dly_q[0] <= sn_q;
      for (int i = 1; i < DL; i++) dv_dly_q[i] <= dv_dly_q[i-1];
    end
  end

  // Final stage: signs, saturation, mask
  dv_side_t                       sd;
  logic [QW:0]                    mag  [gmg_pkg::PARAM_COUNT];
  logic                           neg  [gmg_pkg::PARAM_COUNT];
  logic [DW-1:0]                  dres [gmg_pkg::PARAM_COUNT];
  logic signed [DW+1:0]           aem_s, mv;
  logic [DW-1:0]                  mv_out;
  logic                           err;
  logic                           ez;

  assign sd = dv_dly_q[DL-1];
  assign ez = (sd.e == '0);

  always_comb begin
    err    = sig_zero;
    aem_s  = $signed({2'b00, sd.aem});
    mv     = $signed({{2{base_offset_q[DW-1]}}, base_offset_q}) + (nega ? -aem_s : aem_s);
    mv_out = mv[DW-1:0];
    if (mv[DW+1:DW-1] != 3'b000 && mv[DW+1:DW-1] != 3'b111) begin
      err    = 1'b1;
      mv_out = mv[DW+1] ? SAT_NEG[DW-1:0] : SAT_POS[DW-1:0];
    end

    mag[0] = (QW+1)'(gmg_pkg::ONE_FIX);
    neg[0] = 1'b0;
    mag[1] = (QW+1)'(sd.e);
    neg[1] = 1'b0;
    for (int k = 0; k < NLN; k++) begin
      mag[k+2] = ez ? '0 : (dovf[k] ? {1'b1, {QW{1'b0}}} : {1'b0, dq[k]});
    end
    neg[2] = nega ^ sd.negx;
    neg[3] = nega ^ sd.negy;
    neg[4] = nega;
    neg[5] = nega;

    for (int i = 0; i < gmg_pkg::PARAM_COUNT; i++) begin
      dres[i] = '0;
      if (fit_mask_q[i]) begin
        if (!neg[i]) begin
          if (mag[i] > SAT_POS) begin
            err     = 1'b1;
            dres[i] = SAT_POS[DW-1:0];
          end else begin
            dres[i] = mag[i][DW-1:0];
          end
        end else begin
          if (mag[i] > SAT_NEG) begin
            err     = 1'b1;
            dres[i] = SAT_NEG[DW-1:0];
          end else begin
            dres[i] = DW'(0) - mag[i][DW-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      model_value_o     <= mv_out;
      deriv_offset_o    <= dres[0];
      deriv_amplitude_o <= dres[1];
      deriv_center_x_o  <= dres[2];
      deriv_center_y_o  <= dres[3];
      deriv_width_x_o   <= dres[4];
      deriv_width_y_o   <= dres[5];
      range_error_o     <= err;
    end
  end

  // Checks
  a_stall_holds_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(v_q))
    else $error("pipeline moved during stall");

  a_no_accept_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && out_valid_o) |-> out_ready_i)
    else $error("request taken while result blocked");

  a_gauss_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!deriv_amplitude_o[DW-1] && deriv_amplitude_o <= gmg_pkg::ONE_FIX))
    else $error("gaussian factor out of range");

  a_offset_deriv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (deriv_offset_o == '0 || deriv_offset_o == gmg_pkg::ONE_FIX))
    else $error("offset derivative not zero or one");

endmodule

// ===== test/gaussian_2d_model_gradient_unit_tb.sv =====
// Self-checking testbench for the Gaussian model and gradient unit: directed
// table then random pixels under random register settings. Depends on gmg_pkg and the RTL.
module gaussian_2d_model_gradient_unit_tb;

  localparam int DATA_W      = gmg_pkg::DATA_W;
  localparam int COORD_BITS  = gmg_pkg::COORD_BITS;
  localparam int CFG_IDX_W   = gmg_pkg::CFG_IDX_W;
  localparam int SIG_W       = gmg_pkg::SIG_W;
  localparam int MASK_W      = gmg_pkg::MASK_W;
  localparam int FRAC_BITS   = gmg_pkg::FRAC_BITS;
  localparam int PARAM_COUNT = gmg_pkg::PARAM_COUNT;
  localparam int EXP_INT_MAX = gmg_pkg::EXP_INT_MAX;
  localparam int PIPE_LAT    = gmg_pkg::PIPE_LAT;

  typedef logic [7:0][DATA_W-1:0] pix_result_t;  // 0 model, 1..6 derivs, 7 flag

  typedef enum logic [1:0] {ROW_CFG, ROW_PIX, ROW_PIX_CHK} row_kind_e;
  typedef struct packed {
    row_kind_e               kind;
    gmg_pkg::cfg_reg_e       idx;
    logic [DATA_W-1:0]       data;
    logic [COORD_BITS-1:0]   x;
    logic [COORD_BITS-1:0]   y;
    pix_result_t             want;
  } stim_row_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]          cfg_idx_i = '0;
  logic [DATA_W-1:0]             cfg_wdata_i = '0;
  logic                          in_valid_i = 1'b0;
  logic                          in_ready_o;
  logic [COORD_BITS-1:0]         pixel_x_i = '0;
  logic [COORD_BITS-1:0]         pixel_y_i = '0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic signed [DATA_W-1:0]      model_value_o, deriv_offset_o, deriv_amplitude_o;
  logic signed [DATA_W-1:0]      deriv_center_x_o, deriv_center_y_o;
  logic signed [DATA_W-1:0]      deriv_width_x_o, deriv_width_y_o;
  logic                          range_error_o;

  gaussian_2d_model_gradient_unit uut (.*);

  always #4 clk_i = ~clk_i;

  // Register shadow and exp tables of the predictor
  logic [DATA_W-1:0] sh_offset, sh_amp, sh_cx, sh_cy;
  logic [SIG_W-1:0]  sh_wx, sh_wy;
  logic [MASK_W-1:0] sh_mask;
  longint unsigned   exp_whole [EXP_INT_MAX+1];
  longint unsigned   exp_part [FRAC_BITS+1];

  pix_result_t pending_results [$];
  int          fail_count = 0;
  int          results_taken = 0;
  string       fld_name [8] = '{"model_value", "deriv_offset", "deriv_amplitude",
                                "deriv_center_x", "deriv_center_y", "deriv_width_x",
                                "deriv_width_y", "range_error"};

  // exp(-2^-sh) in Q30, alternating series in Q62
  function automatic longint unsigned neg_exp_series(int sh);
    longint unsigned s, term;
    s = 64'd1 << 62;
    term = 64'd1 << 62;
    for (int k = 1; k <= 30; k++) begin
      term = (term >> sh) / longint'(k);
      s = k[0] ? s - term : s + term;
    end
    return (s + (64'd1 << 31)) >> 32;
  endfunction

  function automatic longint unsigned gauss_exp(longint unsigned a);
    longint unsigned n, p;
    n = a >> FRAC_BITS;
    if (n > EXP_INT_MAX) return 0;
    p = exp_whole[n];
    for (int i = 1; i <= FRAC_BITS; i++)
      if ((a >> (FRAC_BITS - i)) & 1) p = (p * exp_part[i] + (64'd1 << 29)) >> 30;
    return (p + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
  endfunction

  function automatic longint unsigned sigma_ratio(longint unsigned ad, longint unsigned s);
    if (ad >= (s << 3)) return 64'd8 << FRAC_BITS;
    return ((ad << FRAC_BITS) + s / 2) / s;
  endfunction

  function automatic logic [DATA_W-1:0] clamp_field(bit neg, longint unsigned mag,
                                                   inout bit err);
    if (!neg) begin
      if (mag > 64'h7FFF_FFFF) begin err = 1; mag = 64'h7FFF_FFFF; end
      return mag[DATA_W-1:0];
    end
    if (mag > 64'h8000_0000) begin err = 1; mag = 64'h8000_0000; end
    return DATA_W'(64'd0 - mag);
  endfunction

  function automatic longint unsigned deriv_mag(longint unsigned aem, longint unsigned r,
                                                longint unsigned s);
    longint unsigned m;
    m = (aem * r + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    return ((m << FRAC_BITS) + s / 2) / s;
  endfunction

  function automatic pix_result_t predict_gradient(logic [COORD_BITS-1:0] px,
                                                   logic [COORD_BITS-1:0] py);
    longint          dx, dy, amp, mv;
    bit              nx, ny, na, err;
    longint unsigned adx, ady, am, sx, sy, rx, ry, rx2, ry2, e, aem;
    longint unsigned mag [PARAM_COUNT];
    bit              ng [PARAM_COUNT];
    pix_result_t     r;
    dx = longint'(px) * 65536 - longint'($signed(sh_cx));
    dy = longint'(py) * 65536 - longint'($signed(sh_cy));
    amp = longint'($signed(sh_amp));
    nx = dx < 0; ny = dy < 0; na = amp < 0;
    adx = nx ? -dx : dx;
    ady = ny ? -dy : dy;
    am = na ? -amp : amp;
    sx = sh_wx; sy = sh_wy;
    rx = 0; ry = 0; rx2 = 0; ry2 = 0; e = 0; err = 0;
    if (sx == 0 || sy == 0) begin
      err = 1;
    end else begin
      rx = sigma_ratio(adx, sx);
      ry = sigma_ratio(ady, sy);
      rx2 = (rx * rx + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      ry2 = (ry * ry + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      e = gauss_exp((rx2 + ry2) >> 1);
    end
    aem = (am * e + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    mag[0] = 64'd1 << FRAC_BITS; ng[0] = 0;
    mag[1] = e;                  ng[1] = 0;
    ng[2] = na != nx; ng[3] = na != ny; ng[4] = na; ng[5] = na;
    for (int i = 2; i < PARAM_COUNT; i++) mag[i] = 0;
    if (e != 0) begin
      mag[2] = deriv_mag(aem, rx, sx);
      mag[3] = deriv_mag(aem, ry, sy);
      mag[4] = deriv_mag(aem, rx2, sx);
      mag[5] = deriv_mag(aem, ry2, sy);
    end
    mv = longint'($signed(sh_offset)) + (na ? -longint'(aem) : longint'(aem));
    r[0] = clamp_field(mv < 0, (mv < 0) ? -mv : mv, err);
    for (int i = 0; i < PARAM_COUNT; i++)
      r[1+i] = sh_mask[i] ? clamp_field(ng[i], mag[i], err) : '0;
    r[7] = DATA_W'(err);
    return r;
  endfunction

  // Mostly no gap, some short, a few long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  task automatic wait_idle();
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(gmg_pkg::cfg_reg_e idx, logic [DATA_W-1:0] data);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = data;
    case (idx)
      gmg_pkg::REG_BASE_OFFSET: sh_offset = data;
      gmg_pkg::REG_AMPLITUDE:   sh_amp = data;
      gmg_pkg::REG_CENTER_X:    sh_cx = data;
      gmg_pkg::REG_CENTER_Y:    sh_cy = data;
      gmg_pkg::REG_WIDTH_X:     sh_wx = data[SIG_W-1:0];
      gmg_pkg::REG_WIDTH_Y:     sh_wy = data[SIG_W-1:0];
      gmg_pkg::REG_FIT_MASK:    sh_mask = data[MASK_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic send_pixel(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y,
                            bit typed, pix_result_t want);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid_i = 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    pixel_x_i = x;
    pixel_y_i = y;
    // hold the request until accepted
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(typed ? want : predict_gradient(x, y));
    @(negedge clk_i);
  endtask

  function automatic stim_row_t cfg_row(gmg_pkg::cfg_reg_e idx, logic [DATA_W-1:0] data);
    stim_row_t r;
    r = '0;
    r.kind = ROW_CFG; r.idx = idx; r.data = data;
    return r;
  endfunction

  function automatic stim_row_t pix_row(int x, int y);
    stim_row_t r;
    r = '0;
    r.kind = ROW_PIX; r.x = COORD_BITS'(x); r.y = COORD_BITS'(y);
    return r;
  endfunction

  // Rows whose centre and sigma derivatives are all zero
  function automatic stim_row_t chk_row(int x, int y, logic [DATA_W-1:0] mv,
                                        logic [DATA_W-1:0] d0, logic [DATA_W-1:0] d1,
                                        bit err);
    stim_row_t r;
    r = pix_row(x, y);
    r.kind = ROW_PIX_CHK;
    r.want[0] = mv; r.want[1] = d0; r.want[2] = d1; r.want[7] = DATA_W'(err);
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] rand_signed(int unsigned span);
    logic [DATA_W-1:0] v;
    v = $urandom_range(0, span);
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  function automatic logic [DATA_W-1:0] rand_reg(gmg_pkg::cfg_reg_e idx, int ph);
    int r;
    r = $urandom_range(0, 99);
    if (ph == 0) return (idx == gmg_pkg::REG_FIT_MASK) ? 32'h3F : 32'h7FFF_FFFF;
    if (ph == 1)
      return (idx inside {gmg_pkg::REG_WIDTH_X, gmg_pkg::REG_WIDTH_Y,
                          gmg_pkg::REG_FIT_MASK}) ? 32'h0 : 32'h8000_0000;
    case (idx) inside
      gmg_pkg::REG_BASE_OFFSET: return (r < 10) ? $urandom() : rand_signed(1 << 24);
      gmg_pkg::REG_AMPLITUDE:   return (r < 10) ? $urandom() : rand_signed(1000 << 16);
      gmg_pkg::REG_CENTER_X, gmg_pkg::REG_CENTER_Y:
        return (r < 10) ? $urandom() : $urandom_range(0, 4095 << 16);
      gmg_pkg::REG_WIDTH_X, gmg_pkg::REG_WIDTH_Y: begin
        if (r < 3) return 32'h0;
        if (r < 6) return 32'h1;
        if (r < 10) return $urandom() & 32'h7FFF_FFFF;
        return $urandom_range(1 << 13, 300 << 16);
      end
      default: return (r < 50) ? 32'h3F : $urandom_range(0, 63);
    endcase
  endfunction

  // Pixel near the centre along one axis, clamped to the image
  function automatic int near_coord(logic [DATA_W-1:0] c, logic [SIG_W-1:0] w);
    int ci, span, v;
    ci = $signed(c) >>> FRAC_BITS;
    span = int'(w >> FRAC_BITS) * 3 + 2;
    if (span > 4095) span = 4095;
    v = ci + $urandom_range(0, 2 * span) - span;
    return (v < 0) ? 0 : (v > 4095) ? 4095 : v;
  endfunction

  // Result checker
  always @(posedge clk_i) begin
    pix_result_t got, want;
    if (out_valid_o && out_ready_i) begin
      got = {DATA_W'(range_error_o), deriv_width_y_o, deriv_width_x_o, deriv_center_y_o,
             deriv_center_x_o, deriv_amplitude_o, deriv_offset_o, model_value_o};
      results_taken++;
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected result, model_value %h", got[0]);
      end else begin
        want = pending_results.pop_front();
        for (int i = 0; i < 8; i++)
          if (got[i] !== want[i]) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch %s: expected %h, got %h", fld_name[i], want[i], got[i]);
          end
      end
    end
  end

  // Receiver: random stalls, one long hold-off to back up the pipeline
  initial begin
    int  g;
    bit  held;
    held = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held && results_taken >= 500) begin
        held = 1;
        out_ready_i = 1'b0;
        repeat (400) @(negedge clk_i);
      end
      g = gap_len();
      if (g > 0) begin
        out_ready_i = 1'b0;
        repeat (g) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      repeat ($urandom_range(0, 30)) @(negedge clk_i);
    end
  end

  initial begin
    #(8 * 800000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    stim_row_t dir_tab [$];
    int        n;
    exp_whole[0] = 64'd1 << 30;
    exp_whole[1] = neg_exp_series(0);
    for (int i = 2; i <= EXP_INT_MAX; i++)
      exp_whole[i] = (exp_whole[i-1] * exp_whole[1] + (64'd1 << 29)) >> 30;
    exp_part[0] = 64'd1 << 30;
    for (int i = 1; i <= FRAC_BITS; i++) exp_part[i] = neg_exp_series(i);
    sh_offset = '0; sh_amp = gmg_pkg::AMP_RESET; sh_cx = '0; sh_cy = '0;
    sh_wx = gmg_pkg::SIG_RESET; sh_wy = gmg_pkg::SIG_RESET; sh_mask = '1;

    dir_tab.push_back(chk_row(0, 0, gmg_pkg::AMP_RESET, gmg_pkg::ONE_FIX,
                              gmg_pkg::ONE_FIX, 0));
    dir_tab.push_back(chk_row(4095, 4095, 0, gmg_pkg::ONE_FIX, 0, 0));
    dir_tab.push_back(pix_row(1, 0));
    dir_tab.push_back(pix_row(0, 2));
    dir_tab.push_back(pix_row(4095, 0));
    dir_tab.push_back(pix_row(0, 4095));
    dir_tab.push_back(cfg_row(gmg_pkg::REG_CENTER_X, 32'h0002_8000));
    dir_tab.push_back(cfg_row(gmg_pkg::REG_CENTER_Y, 32'h0001_0000));
    dir_tab.push_back(cfg_row(gmg_pkg::REG_WIDTH_X, 32'h0001_8000));
    dir_tab.push_back(cfg_row(gmg_pkg::REG_WIDTH_Y, 32'h0002_8000));
    dir_tab.push_back(pix_row(2, 1));
    dir_tab.push_back(pix_row(1, 3));
    dir_tab.push_back(pix_row(4, 0));
    dir_tab.push_back(cfg_row(gmg_pkg::REG_AMPLITUDE, 32'hFF38_0000));
    dir_tab.push_back(pix_row(1, 1));
    dir_tab.push_back(pix_row(3, 2));
    dir_tab.push_back(cfg_row(gmg_pkg::REG_FIT_MASK, 32'h0));
    dir_tab.push_back(pix_row(3, 1));
    dir_tab.push_back(cfg_row(gmg_pkg::REG_FIT_MASK, 32'h15));
    dir_tab.push_back(pix_row(2, 2));
    // zero sigma: offset only, flag raised
    dir_tab.push_back(cfg_row(gmg_pkg::REG_WIDTH_X, 32'h0));
    dir_tab.push_back(chk_row(2, 1, 0, gmg_pkg::ONE_FIX, 0, 1));
    dir_tab.push_back(cfg_row(gmg_pkg::REG_WIDTH_X, 32'h7FFF_FFFF));
    dir_tab.push_back(pix_row(0, 0));
    // saturated model value at the peak
    dir_tab.push_back(cfg_row(gmg_pkg::REG_WIDTH_X, 32'h0001_0000));
    dir_tab.push_back(cfg_row(gmg_pkg::REG_CENTER_X, 32'h0));
    dir_tab.push_back(cfg_row(gmg_pkg::REG_CENTER_Y, 32'h0));
    dir_tab.push_back(cfg_row(gmg_pkg::REG_BASE_OFFSET, 32'h7FFF_FFFF));
    dir_tab.push_back(cfg_row(gmg_pkg::REG_AMPLITUDE, 32'h7FFF_FFFF));
    dir_tab.push_back(chk_row(0, 0, 32'h7FFF_FFFF, gmg_pkg::ONE_FIX, 0, 1));
    dir_tab.push_back(cfg_row(gmg_pkg::REG_FIT_MASK, 32'h3F));
    dir_tab.push_back(cfg_row(gmg_pkg::REG_CENTER_X, 32'h8000_0000));
    dir_tab.push_back(pix_row(4095, 0));

    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        wait_idle();
        write_reg(dir_tab[i].idx, dir_tab[i].data);
      end else begin
        send_pixel(dir_tab[i].x, dir_tab[i].y, dir_tab[i].kind == ROW_PIX_CHK,
                   dir_tab[i].want);
      end
    end

    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      for (int r = 0; r <= gmg_pkg::REG_FIT_MASK; r++)
        write_reg(gmg_pkg::cfg_reg_e'(r), rand_reg(gmg_pkg::cfg_reg_e'(r), ph));
      n = (ph < 2) ? 40 : 300;
      repeat (n) begin
        if ($urandom_range(0, 9) < 7)
          send_pixel(COORD_BITS'(near_coord(sh_cx, sh_wx)),
                     COORD_BITS'(near_coord(sh_cy, sh_wy)), 0, '0);
        else
          send_pixel(COORD_BITS'($urandom_range(0, 4095)),
                     COORD_BITS'($urandom_range(0, 4095)), 0, '0);
      end
    end

    wait_idle();
    repeat (PIPE_LAT + 10) @(posedge clk_i);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/gmg_pkg.sv
rtl/core/gmg_div.sv
rtl/core/gaussian_2d_model_gradient_unit.sv
test/gaussian_2d_model_gradient_unit_tb.sv
